// ----- rtl/sha1md_pkg.sv -----
// Shared types, constants and round functions of the SHA-1 digest unit.
package sha1md_pkg;

   // Stream widths: one message byte in, five digest words plus error flag out.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned RSP_W    = 168;
   localparam int unsigned RSP_PAD  = RSP_W - 5 * WORD_W - 1;

   // Block buffer and counters.
   localparam int unsigned FILL_W   = 6;
   localparam int unsigned COUNT_W  = 61;
   localparam int unsigned RND_W    = 7;

   localparam logic [FILL_W-1:0]  FILL_LAST   = 6'd63;
   localparam logic [FILL_W-1:0]  FILL_LENGTH = 6'd56;
   localparam logic [RND_W-1:0]   RND_LAST    = 7'd79;
   localparam logic [RND_W-1:0]   RND_EXPAND  = 7'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [BYTE_W-1:0]  PAD_MARK    = 8'h80;

   // Initial chaining value.
   localparam logic [4:0][WORD_W-1:0] H_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   // Round constants, one per group of twenty rounds.
   localparam logic [WORD_W-1:0] K_0 = 32'h5a827999;
   localparam logic [WORD_W-1:0] K_1 = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] K_2 = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] K_3 = 32'hca62c1d6;

   // Controls from the sequencer to the message schedule.
   typedef struct packed {
      logic              byte_wr;
      logic [BYTE_W-1:0] byte_data;
      logic [FILL_W-1:0] fill;
      logic              len_wr;
      logic              shift;
      logic              expand;
   } sched_ctl_type;

   // Controls from the sequencer to the round unit.
   typedef struct packed {
      logic             load;
      logic             step;
      logic             add;
      logic             init;
      logic [RND_W-1:0] round;
   } core_ctl_type;

   // Boolean function of the round.
   function automatic logic [WORD_W-1:0] round_f(input logic [RND_W-1:0] rnd,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] res;
      priority if (rnd < 7'd20) begin
         res = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         res = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         res = (b & c) | (b & d) | (c & d);
      end else begin
         res = b ^ c ^ d;
      end
      return res;
   endfunction

   // Additive constant of the round.
   function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] rnd);
      logic [WORD_W-1:0] res;
      priority if (rnd < 7'd20) begin
         res = K_0;
      end else if (rnd < 7'd40) begin
         res = K_1;
      end else if (rnd < 7'd60) begin
         res = K_2;
      end else begin
         res = K_3;
      end
      return res;
   endfunction

endpackage

// ----- rtl/sha1md_sched.sv -----
// Block buffer and message schedule of the SHA-1 digest unit.
module sha1md_sched import sha1md_pkg::*; (
   input  logic                clock,
   input  sched_ctl_type       ctl,
   input  logic [COUNT_W-1:0]  byte_count,
   output logic [WORD_W-1:0]   wt
);

   logic [15:0][WORD_W-1:0] w_ff;
   logic [15:0][WORD_W-1:0] w_in;
   logic [3:0]              idx;
   logic [WORD_W-1:0]       mix;
   logic [63:0]             bit_len;

   assign idx     = ctl.fill[FILL_W-1:2];
   assign bit_len = {byte_count, 3'b000};

   // Schedule word: the buffered word for the first sixteen rounds, then expanded.
   assign mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign wt  = ctl.expand ? {mix[WORD_W-2:0], mix[WORD_W-1]} : w_ff[0];

   // Byte packing, length words and the sliding window of the schedule.
   always_comb begin
      w_in = w_ff;
      if (ctl.shift) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = wt;
      end else begin
         if (ctl.byte_wr) begin
            unique case (ctl.fill[1:0])
               2'd0:    w_in[idx] = {ctl.byte_data, 24'h000000};
               2'd1:    w_in[idx][23:16] = ctl.byte_data;
               2'd2:    w_in[idx][15:8] = ctl.byte_data;
               default: w_in[idx][7:0] = ctl.byte_data;
            endcase
         end
         if (ctl.len_wr) begin
            w_in[14] = bit_len[63:32];
            w_in[15] = bit_len[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

endmodule

// ----- rtl/sha1md_core.sv -----
// Shared round unit and chaining value of the SHA-1 digest unit.
module sha1md_core import sha1md_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  core_ctl_type            ctl,
   input  logic [WORD_W-1:0]       wt,
   output logic [4:0][WORD_W-1:0]  hash
);

   logic [4:0][WORD_W-1:0] h_ff;
   logic [4:0][WORD_W-1:0] h_in;
   logic [4:0][WORD_W-1:0] v_ff;
   logic [4:0][WORD_W-1:0] v_in;
   logic [WORD_W-1:0]      temp;

   assign hash = h_ff;

   // One compression round: v[0..4] hold a, b, c, d, e.
   assign temp = {v_ff[0][26:0], v_ff[0][31:27]}
               + round_f(ctl.round, v_ff[1], v_ff[2], v_ff[3])
               + v_ff[4] + wt + round_k(ctl.round);

   // Working variables load from the chaining value, then step once per round.
   always_comb begin
      v_in = v_ff;
      if (ctl.load) begin
         v_in = h_ff;
      end else if (ctl.step) begin
         v_in[0] = temp;
         v_in[1] = v_ff[0];
         v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3];
      end
   end

   // Chaining value: feed-forward after the last round, back to initial per message.
   always_comb begin
      h_in = h_ff;
      if (ctl.init) begin
         h_in = H_INIT;
      end else if (ctl.add) begin
         for (int i = 0; i < 5; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= H_INIT;
      end else begin
         h_ff <= h_in;
      end
      v_ff <= v_in;
   end

endmodule

// ----- rtl/sha1_message_digest_unit.sv -----
// Top level of the SHA-1 digest unit: stream ports and the round sequencer.
//
// Takes one message byte per beat and returns the 160-bit SHA-1 digest after
// the beat that carries tlast. Every 64th byte holds the input while the
// block runs through its 80 rounds in the one shared round unit and the
// chaining-value add. After tlast the padding is written one byte a cycle,
// with a compression whenever the block fills, up to byte 56 of the last
// block; the length words, their compression and the loading of the result
// follow. The input stays held until the result is loaded, which also waits
// while an earlier result still sits unaccepted in the output register. A
// result waits in that register while the next message bytes are accepted. A
// message beyond 2^61-1 bytes sets the error bit.
module sha1_message_digest_unit import sha1md_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic              req_tuser,   // [0] byte_valid
   input  logic              req_tlast,   // end of message
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // digest_word0..4 [159:0], length_error [160]
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_ZERO,
      S_ROUND,
      S_ADD,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   state_type              ret_ff, ret_in;
   state_type              after_byte;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [RND_W-1:0]       round_ff, round_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   take;
   sched_ctl_type          sc;
   core_ctl_type           cc;
   logic [WORD_W-1:0]      wt;
   logic [4:0][WORD_W-1:0] hash;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   sha1md_sched u_sched (
      .clock      (clock),
      .ctl        (sc),
      .byte_count (count_ff),
      .wt         (wt)
   );

   sha1md_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (cc),
      .wt    (wt),
      .hash  (hash)
   );

   // Sequencer: byte intake, padding, rounds, feed-forward and result load.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      sc           = '0;
      cc           = '0;
      sc.fill      = fill_ff;
      sc.expand    = (round_ff >= RND_EXPAND);
      cc.round     = round_ff;
      take         = req_tuser && !ovf_ff && (count_ff != COUNT_MAX);
      after_byte   = req_tlast ? S_PAD : S_IDLE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser && !take) begin
                  ovf_in = 1'b1;
               end
               state_in = after_byte;
               if (take) begin
                  sc.byte_wr   = 1'b1;
                  sc.byte_data = req_tdata;
                  fill_in      = fill_ff + 1'b1;
                  count_in     = count_ff + 1'b1;
                  if (fill_ff == FILL_LAST) begin
                     state_in = S_ROUND;
                     ret_in   = after_byte;
                     cc.load  = 1'b1;
                     round_in = '0;
                  end
               end
            end
         end
         S_PAD: begin
            // The end marker byte.
            sc.byte_wr   = 1'b1;
            sc.byte_data = PAD_MARK;
            fill_in      = fill_ff + 1'b1;
            state_in     = S_ZERO;
            if (fill_ff == FILL_LAST) begin
               state_in = S_ROUND;
               ret_in   = S_ZERO;
               cc.load  = 1'b1;
               round_in = '0;
            end
         end
         S_ZERO: begin
            if (fill_ff == FILL_LENGTH) begin
               // Length words close the final block.
               sc.len_wr = 1'b1;
               state_in  = S_ROUND;
               ret_in    = S_OUT;
               cc.load   = 1'b1;
               round_in  = '0;
            end else begin
               sc.byte_wr   = 1'b1;
               sc.byte_data = '0;
               fill_in      = fill_ff + 1'b1;
               if (fill_ff == FILL_LAST) begin
                  state_in = S_ROUND;
                  ret_in   = S_ZERO;
                  cc.load  = 1'b1;
                  round_in = '0;
               end
            end
         end
         S_ROUND: begin
            sc.shift = 1'b1;
            cc.step  = 1'b1;
            round_in = round_ff + 1'b1;
            if (round_ff == RND_LAST) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cc.add   = 1'b1;
            fill_in  = '0;
            state_in = ret_ff;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD{1'b0}}, ovf_ff,
                               hash[4], hash[3], hash[2], hash[1], hash[0]};
               cc.init      = 1'b1;
               count_in     = '0;
               ovf_in       = 1'b0;
               fill_in      = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- rtl/sha1md_checker.sv -----
// Port-level checks of the SHA-1 digest unit and their binding.
module sha1md_checker import sha1md_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tlast,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A stalled result beat keeps its digest.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The end of a message starts padding, so input stalls next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input ready right after end of message");

   // A new result appears only from the busy output step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result raised while input was idle");

endmodule

bind sha1_message_digest_unit sha1md_checker u_checker (.*);
